/* rtl/core/sspq_pkg.sv */
// Shared types, codes and defaults for the stable sorted priority queue.
`default_nettype none
package sspq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int PRIO_W_DEF = 8;
  localparam int CHAR_W     = 8;
  localparam int PRIO_IN_W  = 8;
  localparam int FILL_W     = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } ctl_t;

endpackage
`default_nettype wire

/* rtl/core/sspq_if.sv */
// Request and result channel interfaces of the priority queue.
`default_nettype none
interface sspq_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_char;
  logic [7:0] prio;

  modport source (output valid, cmd, data_char, prio, input ready);
  modport sink   (input valid, cmd, data_char, prio, output ready);
endinterface

interface sspq_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic [4:0] fill;

  modport source (output valid, out_char, status, fill, input ready);
  modport sink   (input valid, out_char, status, fill, output ready);
endinterface
`default_nettype wire

/* rtl/core/sspq_cell.sv */
// One queue slot: holds an entry, shifts left on removal, right on insertion.
`default_nettype none
module sspq_cell #(
  parameter int PRIO_W = sspq_pkg::PRIO_W_DEF
) (
  input  wire                        clk,
  input  sspq_pkg::ctl_t             ctl,
  input  wire                        occ,
  input  wire                        tail,
  input  wire [sspq_pkg::CHAR_W-1:0] new_ch,
  input  wire [PRIO_W-1:0]           new_prio,
  input  wire                        left_gt,
  input  wire [sspq_pkg::CHAR_W-1:0] left_ch,
  input  wire [PRIO_W-1:0]           left_prio,
  input  wire [sspq_pkg::CHAR_W-1:0] right_ch,
  input  wire [PRIO_W-1:0]           right_prio,
  output logic [sspq_pkg::CHAR_W-1:0] ch,
  output logic [PRIO_W-1:0]           prio,
  output logic                        gt
);
  import sspq_pkg::*;

  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  assign gt   = occ && (prio_r > new_prio);
  assign ch   = ch_r;
  assign prio = prio_r;

  always_comb begin
    ch_nxt   = ch_r;
    prio_nxt = prio_r;
    if (ctl.deq) begin
      ch_nxt   = right_ch;
      prio_nxt = right_prio;
    end else if (ctl.enq) begin
      if (left_gt) begin
        ch_nxt   = left_ch;
        prio_nxt = left_prio;
      end else if (gt || tail) begin
        ch_nxt   = new_ch;
        prio_nxt = new_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    prio_r <= prio_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/stable_sorted_priority_queue_top.sv */
// Top level of the stable sorted priority queue built from a row of shifting cells.
//
// Usage: each request on in_req carries cmd (enqueue or dequeue), data_char and
// prio. Every request gives exactly one result on out_res: the removed character
// (zero unless dequeued), a status (enqueued, dequeued, underflow, overflow) and
// the fill after the operation. Entries leave in ascending priority value, ties
// in arrival order. An enqueue into a full queue is dropped with overflow; a
// dequeue of an empty queue reports underflow; neither changes the contents.
// Result: registered, valid in the cycle after the request is taken. Throughput:
// one request per cycle while in_req.ready is high; every cell compares its priority
// with the incoming one in parallel and shifts with its neighbour in the same cycle.
// Stall: the result register holds until out_res.ready; in_req.ready is high
// whenever the result register is empty or being emptied in the same cycle.
// Reset: synchronous, active low; the queue comes up empty with no result pending.
`default_nettype none
module stable_sorted_priority_queue_top #(
  parameter int DEPTH  = sspq_pkg::DEPTH_DEF,
  parameter int PRIO_W = sspq_pkg::PRIO_W_DEF
) (
  input wire          clk,
  input wire          rst_n,
  sspq_req_if.sink    in_req,
  sspq_res_if.source  out_res
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_ch_r, out_ch_nxt;
  status_t           status_r, status_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic              accept;
  logic              empty, full;
  ctl_t              ctl;
  logic [PRIO_W-1:0] new_prio;
  logic [PRIO_W+PRIO_IN_W-1:0] prio_ext;
  logic [CNT_W+FILL_W-1:0]     fill_ext;

  logic [CHAR_W-1:0] cell_ch   [DEPTH];
  logic [PRIO_W-1:0] cell_prio [DEPTH];
  logic              cell_gt   [DEPTH];

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign empty        = (cnt_r == '0);
  assign full         = (cnt_r == CNT_W'(DEPTH));
  assign prio_ext     = {{PRIO_W{1'b0}}, in_req.prio};
  assign new_prio     = prio_ext[PRIO_W-1:0];

  assign ctl.enq = accept && (in_req.cmd == CMD_ENQ) && !full;
  assign ctl.deq = accept && (in_req.cmd == CMD_DEQ) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic              l_gt;
      logic [CHAR_W-1:0] l_ch, r_ch;
      logic [PRIO_W-1:0] l_prio, r_prio;

      if (i == 0) begin : g_first
        assign l_gt   = 1'b0;
        assign l_ch   = in_req.data_char;
        assign l_prio = new_prio;
      end else begin : g_mid
        assign l_gt   = cell_gt[i-1];
        assign l_ch   = cell_ch[i-1];
        assign l_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_ch   = cell_ch[i];
        assign r_prio = cell_prio[i];
      end else begin : g_inner
        assign r_ch   = cell_ch[i+1];
        assign r_prio = cell_prio[i+1];
      end

      sspq_cell #(
        .PRIO_W (PRIO_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (CNT_W'(i) < cnt_r),
        .tail       (CNT_W'(i) == cnt_r),
        .new_ch     (in_req.data_char),
        .new_prio   (new_prio),
        .left_gt    (l_gt),
        .left_ch    (l_ch),
        .left_prio  (l_prio),
        .right_ch   (r_ch),
        .right_prio (r_prio),
        .ch         (cell_ch[i]),
        .prio       (cell_prio[i]),
        .gt         (cell_gt[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_ch_nxt    = out_ch_r;
    status_nxt    = status_r;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_ch_nxt    = '0;
      if (in_req.cmd == CMD_DEQ) begin
        if (empty) begin
          status_nxt = ST_UNDER;
        end else begin
          status_nxt = ST_DEQ;
          out_ch_nxt = cell_ch[0];
        end
      end else begin
        status_nxt = full ? ST_OVER : ST_ENQ;
      end
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, cnt_nxt};
  assign fill_nxt = accept ? fill_ext[FILL_W-1:0] : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ch_r <= out_ch_nxt;
    status_r <= status_nxt;
    fill_r   <= fill_nxt;
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.out_char = out_ch_r;
  assign out_res.status   = status_r;
  assign out_res.fill     = fill_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("request taken without result");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.cmd == CMD_DEQ && empty) |=> (status_r == ST_UNDER && cnt_r == '0))
    else $error("empty dequeue not reported as underflow");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("occupancy changed without request");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the stable sorted priority queue: random and directed requests.
`timescale 1ns / 1ps
module tb;
  import sspq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [CHAR_W-1:0]    ch;
    logic [PRIO_IN_W-1:0] pr;
  } held_entry_t;

  typedef struct {
    logic [CHAR_W-1:0] out_char;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } pq_result_t;

  class pq_order_board;
    held_entry_t held[$];
    pq_result_t  due_results[$];
    int unsigned errors = 0;

    function void take_request(logic cmd, logic [CHAR_W-1:0] ch, logic [PRIO_IN_W-1:0] pr);
      pq_result_t  res;
      held_entry_t ent;
      int          pos;
      res.out_char = '0;
      if (cmd == CMD_DEQ) begin
        if (held.size() == 0) begin
          res.status = ST_UNDER;
        end else begin
          ent          = held.pop_front();
          res.out_char = ent.ch;
          res.status   = ST_DEQ;
        end
      end else if (held.size() >= QDEPTH) begin
        res.status = ST_OVER;
      end else begin
        pos = held.size();
        for (int i = 0; i < held.size(); i++) begin
          if (held[i].pr > pr) begin
            pos = i;
            break;
          end
        end
        ent.ch = ch;
        ent.pr = pr;
        held.insert(pos, ent);
        res.status = ST_ENQ;
      end
      res.fill = FILL_W'(held.size());
      due_results.push_back(res);
    endfunction

    function void match_result(logic [CHAR_W-1:0] ch, logic [1:0] st, logic [FILL_W-1:0] fill);
      pq_result_t exp_res;
      if (due_results.size() == 0) begin
        $error("result with nothing awaited: out_char %0d status %0d fill %0d", ch, st, fill);
        errors++;
        return;
      end
      exp_res = due_results.pop_front();
      if (ch !== exp_res.out_char) begin
        $error("out_char: expected %0d, got %0d", exp_res.out_char, ch);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (fill !== exp_res.fill) begin
        $error("fill: expected %0d, got %0d", exp_res.fill, fill);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_count = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  sspq_req_if in_req ();
  sspq_res_if out_res ();

  pq_order_board board = new();

  stable_sorted_priority_queue_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(logic cmd, logic [CHAR_W-1:0] ch, logic [PRIO_IN_W-1:0] pr);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req.valid     <= 1'b1;
    in_req.cmd       <= cmd;
    in_req.data_char <= ch;
    in_req.prio      <= pr;
    do @(posedge clk); while (!in_req.ready);
    board.take_request(cmd, ch, pr);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    out_res.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap(receiver_calm);
      if (stall > 0) begin
        @(negedge clk);
        out_res.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!out_res.valid);
      board.match_result(out_res.out_char, out_res.status, out_res.fill);
    end
  end

  initial begin
    logic [PRIO_IN_W-1:0] fill_prios[15];
    int                   enq_pct;
    bit                   narrow;
    logic                 cmd;
    logic [PRIO_IN_W-1:0] pr;

    fill_prios = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd1, 8'd254, 8'd0, 8'd128,
                   8'd7, 8'd255, 8'd64, 8'd64, 8'd200, 8'd3, 8'd128};
    in_req.valid     = 1'b0;
    in_req.cmd       = CMD_ENQ;
    in_req.data_char = '0;
    in_req.prio      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_req(CMD_DEQ, 8'hFF, 8'hFF);
    send_req(CMD_ENQ, 8'hFF, 8'hFF);
    send_req(CMD_DEQ, 8'h55, 8'hAA);
    send_req(CMD_ENQ, 8'h00, 8'h00);
    foreach (fill_prios[i]) send_req(CMD_ENQ, CHAR_W'(8'hA0 + i), fill_prios[i]);
    send_req(CMD_ENQ, 8'h5A, 8'h00);
    send_req(CMD_DEQ, 8'h00, 8'h00);
    send_req(CMD_ENQ, 8'hC3, 8'd128);
    send_req(CMD_ENQ, 8'h3C, 8'd255);

    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        default: enq_pct = $urandom_range(35, 65);
      endcase
      narrow        = (ph % 3 == 1);
      sender_calm   = (ph % 5 == 2);
      receiver_calm = (ph % 5 == 2) || (ph % 5 == 3);
      if (ph == 10) wait_drained();
      for (int n = 0; n < 100; n++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        pr  = narrow ? PRIO_IN_W'($urandom_range(0, 3)) : PRIO_IN_W'($urandom_range(0, 255));
        send_req(cmd, CHAR_W'($urandom_range(0, 255)), pr);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
